[rtl/assert_macros.svh]
// assertion helpers for the checker file
// both expect clk in scope; SFS_ASSERT also expects rst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define SFS_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sfs check failed");

// checked at every edge, reset included
`define SFS_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("sfs check failed");

`endif

[rtl/sfs_pkg.sv]
// ----------------------------------------------------------------------------
// sfs_pkg
// Shared types and constants of the sprite frame sequencer: beat structs,
// configuration register set, register indexes and operation codes.
// ----------------------------------------------------------------------------
package sfs_pkg;

  localparam int NOTIFY_SLOTS_DEF = 4;
  localparam int FRAME_BITS_DEF   = 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int HIT_W      = 4;
  localparam int SLOT_W     = 8;

  localparam logic OP_ADVANCE = 1'b0;
  localparam logic OP_CLEAR   = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_TIME    = 3'd0,
    REG_PLAY_RATE     = 3'd1,
    REG_FRAME_COUNT   = 3'd2,
    REG_PLAY_MODE     = 3'd3,
    REG_NOTIFY_FRAMES = 3'd4,
    REG_NOTIFY_ENABLE = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic        operation;
    logic [15:0] delta_time;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]       frame_index;
    logic             finished;
    logic [HIT_W-1:0] notify_hits;
  } out_beat_t;

  typedef struct packed {
    logic [31:0]      frame_time;
    logic [15:0]      play_rate;
    logic [7:0]       frame_count;
    logic [1:0]       play_mode;
    logic [31:0]      notify_frames;
    logic [HIT_W-1:0] notify_enable;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    frame_time:    32'h0001_0000,
    play_rate:     16'h0100,
    frame_count:   8'd0,
    play_mode:     2'b10,
    notify_frames: 32'd0,
    notify_enable: '0
  };

endpackage

[rtl/sprite_frame_sequencer.sv]
// ----------------------------------------------------------------------------
// sprite_frame_sequencer
// Sprite animation frame stepper with looping, reverse play and notifies.
//
// in_ channel: one beat per tick or clear (operation, delta_time).
// out_ channel: exactly one beat per input beat, in order (frame_index,
//   finished, notify_hits).
// cfg_ port: write-only register file, written when cfg_we is high; write it
//   only while no beat is in flight.
// Path: an accepted beat waits in the input register and is stepped into the
//   output register, driven on out_, once the output is free.
// Throughput: one beat per cycle unless out_ stalls; the step (16x16 multiply,
//   saturating add, frame compare, notify compares) sits between the input
//   and output registers, and the state loop closes in that same cycle.
// Reset: config registers return to their reset values,
//   frame and time cleared, no notify marked, both stages empty.
// Stall: a held out_ beat keeps its value; one more beat waits in the input
//   register, after which in_ready drops.
// ----------------------------------------------------------------------------
module sprite_frame_sequencer #(
  parameter int NOTIFY_SLOTS = sfs_pkg::NOTIFY_SLOTS_DEF,
  parameter int FRAME_BITS   = sfs_pkg::FRAME_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  sfs_pkg::in_beat_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output sfs_pkg::out_beat_t              out_data,
  input  logic                            cfg_we,
  input  logic [sfs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sfs_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import sfs_pkg::*;

  logic      in_vld_r, in_vld_nxt;
  in_beat_t  in_item_r;
  logic      out_vld_r, out_vld_nxt;
  out_beat_t out_data_r;
  out_beat_t step_res;
  cfg_t      cfg;
  logic      adv;

  assign adv        = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready   = !in_vld_r || adv;
  assign in_vld_nxt = (in_valid && in_ready) || (in_vld_r && !adv);
  assign out_vld_nxt = adv || (out_vld_r && !out_ready);

  sfs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  sfs_core #(
    .NOTIFY_SLOTS (NOTIFY_SLOTS),
    .FRAME_BITS   (FRAME_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (adv),
    .item    (in_item_r),
    .cfg     (cfg),
    .res     (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_data;
    end
    if (adv) begin
      out_data_r <= step_res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule

[rtl/sfs_cfg.sv]
// ----------------------------------------------------------------------------
// sfs_cfg
// Configuration register file, written through a plain indexed write port.
// ----------------------------------------------------------------------------
module sfs_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [sfs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sfs_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output sfs_pkg::cfg_t                     cfg
);
  import sfs_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_TIME:    cfg_nxt.frame_time    = cfg_wdata;
        REG_PLAY_RATE:     cfg_nxt.play_rate     = cfg_wdata[15:0];
        REG_FRAME_COUNT:   cfg_nxt.frame_count   = cfg_wdata[7:0];
        REG_PLAY_MODE:     cfg_nxt.play_mode     = cfg_wdata[1:0];
        REG_NOTIFY_FRAMES: cfg_nxt.notify_frames = cfg_wdata;
        REG_NOTIFY_ENABLE: cfg_nxt.notify_enable = cfg_wdata[HIT_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[rtl/sfs_core.sv]
// ----------------------------------------------------------------------------
// sfs_core
// Animation state and the combinational step: scaled time accumulate,
// frame advance or clear, end handling and notify slot matching.
// ----------------------------------------------------------------------------
module sfs_core #(
  parameter int NOTIFY_SLOTS = sfs_pkg::NOTIFY_SLOTS_DEF,
  parameter int FRAME_BITS   = sfs_pkg::FRAME_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  sfs_pkg::in_beat_t   item,
  input  sfs_pkg::cfg_t       cfg,
  output sfs_pkg::out_beat_t  res
);
  import sfs_pkg::*;

  localparam int SLOT_LIMIT = (NOTIFY_SLOTS < HIT_W) ? NOTIFY_SLOTS : HIT_W;
  localparam int CMP_W      = ((FRAME_BITS > SLOT_W) ? FRAME_BITS : SLOT_W) + 1;

  logic [31:0]           acc_r, acc_nxt;
  logic [FRAME_BITS-1:0] frame_r, frame_nxt;
  logic [HIT_W-1:0]      called_r, called_nxt;

  logic [31:0]           prod;
  logic [32:0]           sum;
  logic [31:0]           acc_sat;
  logic                  do_step;
  logic                  reverse;
  logic                  loop_on;
  logic [CMP_W-1:0]      fc_ext;
  logic [FRAME_BITS-1:0] last_frame;
  logic [CMP_W-1:0]      fwd_ext;
  logic [CMP_W-1:0]      frame_ext;
  logic [HIT_W-1:0]      called_mid;
  logic [HIT_W-1:0]      hits;
  logic                  finished;

  assign reverse    = cfg.play_mode[0];
  assign loop_on    = cfg.play_mode[1];
  assign fc_ext     = CMP_W'(cfg.frame_count);
  assign last_frame = FRAME_BITS'(fc_ext - CMP_W'(1));
  assign fwd_ext    = CMP_W'(frame_r) + CMP_W'(1);

  assign prod    = {16'd0, item.delta_time} * {16'd0, cfg.play_rate};
  assign sum     = {1'b0, acc_r} + {9'd0, prod[31:8]};
  assign acc_sat = sum[32] ? '1 : sum[31:0];
  assign do_step = (acc_sat >= cfg.frame_time);

  always_comb begin
    acc_nxt    = acc_r;
    frame_nxt  = frame_r;
    called_mid = called_r;
    finished   = 1'b0;
    hits       = '0;
    if (item.operation == OP_CLEAR) begin
      called_mid = '0;
      if (cfg.frame_count != 8'd0) begin
        frame_nxt = reverse ? last_frame : '0;
        acc_nxt   = '0;
      end
    end else if (cfg.frame_count != 8'd0) begin
      acc_nxt = acc_sat;
      if (do_step) begin
        acc_nxt = acc_sat - cfg.frame_time;
        if (reverse) begin
          if (frame_r == '0) begin
            finished = 1'b1;
            if (loop_on) begin
              frame_nxt  = last_frame;
              called_mid = '0;
            end else begin
              frame_nxt = '0;
            end
          end else begin
            frame_nxt = frame_r - FRAME_BITS'(1);
          end
        end else begin
          if (fwd_ext >= fc_ext) begin
            finished = 1'b1;
            if (loop_on) begin
              frame_nxt  = '0;
              called_mid = '0;
            end else begin
              frame_nxt = last_frame;
            end
          end else begin
            frame_nxt = FRAME_BITS'(fwd_ext);
          end
        end
      end
      for (int k = 0; k < SLOT_LIMIT; k++) begin
        if (cfg.notify_enable[k] && !called_mid[k] &&
            (CMP_W'(cfg.notify_frames[SLOT_W*k +: SLOT_W]) == CMP_W'(frame_nxt))) begin
          hits[k] = 1'b1;
        end
      end
    end
    called_nxt = called_mid | hits;
  end

  assign frame_ext = CMP_W'(frame_nxt);

  always_comb begin
    res.frame_index = frame_ext[7:0];
    res.finished    = finished;
    res.notify_hits = hits;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= '0;
      frame_r  <= '0;
      called_r <= '0;
    end else if (step_en) begin
      acc_r    <= acc_nxt;
      frame_r  <= frame_nxt;
      called_r <= called_nxt;
    end
  end

endmodule

[rtl/sfs_checker.sv]
// ----------------------------------------------------------------------------
// sfs_checker
// Port-level checks of the sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sfs_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input sfs_pkg::out_beat_t              out_data
);
  import sfs_pkg::*;

  // a stalled result beat holds
  `SFS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data))
  // reset empties the output stage
  `SFS_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_valid)
  // with the output stage empty the input side is never blocked
  `SFS_ASSERT(a_ready_free, !out_valid |-> in_ready)
  // an accepted beat reaches the output through the input and output registers
  `SFS_ASSERT(a_latency, in_valid && in_ready |-> ##2 out_valid)

endmodule

bind sprite_frame_sequencer sfs_checker u_sfs_checker (.*);
